>>> sv/mmpq_pkg.sv
// ----------------------------------------------------------------------------
// mmpq_pkg
// Shared widths and codes for the min/max priority queue.
// ----------------------------------------------------------------------------
package mmpq_pkg;

    // Fixed field widths
    localparam int VAL_W = 32;
    localparam int CNT_W = 6;
    localparam int REQ_W = 2;
    localparam int STS_W = 2;

    // Largest count the occupancy and capacity fields can express
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    // Capacity after reset
    localparam logic [CNT_W-1:0] CAPACITY_RST = CNT_W'(32);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEL_MIN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEL_MAX = 2'd2;

    // Status codes
    localparam logic [STS_W-1:0] STS_DONE = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

endpackage

>>> sv/mmpq_ram.sv
// ----------------------------------------------------------------------------
// mmpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mmpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/min_max_priority_queue.sv
// ----------------------------------------------------------------------------
// min_max_priority_queue
// Double-ended priority queue kept as an unsorted array in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one request item (insert, remove-min, remove-max).
//   m_* channel returns one result item per request: status, removed value
//   and occupancy after the request. cfg_* writes the capacity register and
//   is always ready; write it only while the queue is idle.
// Sequencing:
//   Insert, full/empty answers and unused codes go straight to FINISH,
//   which posts the result once the output slot is free. A removal reads
//   every stored entry through the single read port of the entry RAM, then
//   moves the entries after the removed one down by one (none if it was the
//   last), then posts its result from FINISH. One request is in work at a
//   time; s_ready is high while the queue is idle, so the next item can be
//   taken once a result is posted.
// Reset:
//   aresetn (synchronous, active low) empties the queue and sets capacity
//   to 32. Entry RAM contents are not cleared; only stored entries are read.
// Stalls:
//   A result waits in the output register while m_ready is low; the next
//   request is accepted meanwhile and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module min_max_priority_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mmpq_pkg::REQ_W-1:0]        s_req_type,
    input  logic signed [mmpq_pkg::VAL_W-1:0] s_value,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mmpq_pkg::STS_W-1:0]        m_status,
    output logic signed [mmpq_pkg::VAL_W-1:0] m_removed_value,
    output logic [mmpq_pkg::CNT_W-1:0]        m_occupancy,
    // Capacity register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mmpq_pkg::CNT_W-1:0]        cfg_data
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = mmpq_pkg::CNT_W;
    localparam int VAL_W = mmpq_pkg::VAL_W;
    localparam int CMP_W = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;
    localparam int DEPTH_CAP = (QUEUE_DEPTH > mmpq_pkg::CNT_MAX) ?
                               mmpq_pkg::CNT_MAX : QUEUE_DEPTH;
    localparam logic [CNT_W-1:0] DEPTH_LIM = CNT_W'(DEPTH_CAP);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t                            state_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  capacity_reg;
    logic                              want_min_reg;
    logic [ADDR_W-1:0]                 dat_idx_reg;
    logic [ADDR_W-1:0]                 pos_reg;
    logic signed [VAL_W-1:0]           best_reg;
    logic [mmpq_pkg::STS_W-1:0]        res_status_reg;
    logic signed [VAL_W-1:0]           res_value_reg;
    logic                              m_valid_reg;
    logic [mmpq_pkg::STS_W-1:0]        m_status_reg;
    logic signed [VAL_W-1:0]           m_value_reg;
    logic [CNT_W-1:0]                  m_occ_reg;

    logic                              s_fire;
    logic                              full;
    logic [CMP_W-1:0]                  cnt_ext;
    logic [CMP_W-1:0]                  cnt_m1;
    logic [ADDR_W-1:0]                 last_idx;
    logic                              at_last;
    logic                              is_better;
    logic signed [VAL_W-1:0]           best_now;
    logic [ADDR_W-1:0]                 pos_now;
    logic                              out_free;

    logic                              ram_wr_en;
    logic [ADDR_W-1:0]                 ram_wr_addr;
    logic [VAL_W-1:0]                  ram_wr_data;
    logic                              ram_rd_en;
    logic [ADDR_W-1:0]                 ram_rd_addr;
    logic [VAL_W-1:0]                  ram_rd_data;

    // Entry storage
    mmpq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Handshakes and occupancy checks
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free = !m_valid_reg || m_ready;
    assign full = (count_reg >= capacity_reg) || (count_reg >= DEPTH_LIM);
    assign cnt_ext = CMP_W'(count_reg);
    assign cnt_m1 = cnt_ext - CMP_W'(1);
    assign last_idx = cnt_m1[ADDR_W-1:0];
    assign at_last = (dat_idx_reg == last_idx);

    // Running extreme; the first entry always seeds it, ties keep the oldest
    always_comb begin
        if (want_min_reg) begin
            is_better = ($signed(ram_rd_data) < best_reg);
        end else begin
            is_better = ($signed(ram_rd_data) > best_reg);
        end
        if (dat_idx_reg == '0) begin
            is_better = 1'b1;
        end
        best_now = is_better ? $signed(ram_rd_data) : best_reg;
        pos_now = is_better ? dat_idx_reg : pos_reg;
    end

    // RAM port control: scan reads one entry a cycle, shift copies i+1 to i
    always_comb begin
        ram_wr_en = 1'b0;
        ram_wr_addr = dat_idx_reg - ADDR_W'(1);
        ram_wr_data = ram_rd_data;
        ram_rd_en = 1'b0;
        ram_rd_addr = dat_idx_reg + ADDR_W'(1);
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_req_type == mmpq_pkg::REQ_INSERT && !full) begin
                    ram_wr_en = 1'b1;
                    ram_wr_addr = cnt_ext[ADDR_W-1:0];
                    ram_wr_data = s_value;
                end
                if (s_fire && count_reg != '0 &&
                    (s_req_type inside {mmpq_pkg::REQ_DEL_MIN, mmpq_pkg::REQ_DEL_MAX})) begin
                    ram_rd_en = 1'b1;
                    ram_rd_addr = '0;
                end
            end
            ST_SCAN: begin
                if (!at_last) begin
                    ram_rd_en = 1'b1;
                end else if (pos_now != last_idx) begin
                    ram_rd_en = 1'b1;
                    ram_rd_addr = pos_now + ADDR_W'(1);
                end
            end
            ST_SHIFT: begin
                ram_wr_en = 1'b1;
                ram_rd_en = !at_last;
            end
            default: begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    // Sequencer, occupancy, capacity and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            capacity_reg <= mmpq_pkg::CAPACITY_RST;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                capacity_reg <= cfg_data;
            end
            // FINISH posts the next result itself when the slot drains
            if (m_valid_reg && m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        res_value_reg <= '0;
                        case (s_req_type)
                            mmpq_pkg::REQ_INSERT: begin
                                state_reg <= ST_FINISH;
                                if (full) begin
                                    res_status_reg <= mmpq_pkg::STS_FULL;
                                end else begin
                                    res_status_reg <= mmpq_pkg::STS_DONE;
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            mmpq_pkg::REQ_DEL_MIN, mmpq_pkg::REQ_DEL_MAX: begin
                                if (count_reg == '0) begin
                                    res_status_reg <= mmpq_pkg::STS_EMPTY;
                                    state_reg <= ST_FINISH;
                                end else begin
                                    res_status_reg <= mmpq_pkg::STS_DONE;
                                    want_min_reg <= (s_req_type == mmpq_pkg::REQ_DEL_MIN);
                                    dat_idx_reg <= '0;
                                    state_reg <= ST_SCAN;
                                end
                            end
                            default: begin
                                res_status_reg <= mmpq_pkg::STS_DONE;
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    best_reg <= best_now;
                    pos_reg <= pos_now;
                    if (!at_last) begin
                        dat_idx_reg <= dat_idx_reg + ADDR_W'(1);
                    end else begin
                        res_value_reg <= best_now;
                        if (pos_now != last_idx) begin
                            dat_idx_reg <= pos_now + ADDR_W'(1);
                            state_reg <= ST_SHIFT;
                        end else begin
                            count_reg <= count_reg - CNT_W'(1);
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_SHIFT: begin
                    if (!at_last) begin
                        dat_idx_reg <= dat_idx_reg + ADDR_W'(1);
                    end else begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_value_reg <= res_value_reg;
                        m_occ_reg <= count_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_removed_value = m_value_reg;
    assign m_occupancy = m_occ_reg;

    // Occupancy never passes the storage depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_LIM)
        else $error("occupancy beyond storage depth");

    // Scan and shift never address past the last stored entry
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_SHIFT) |->
            (count_reg != '0 && dat_idx_reg <= last_idx))
        else $error("entry index past last stored entry");

    // An empty answer reports an empty queue
    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == mmpq_pkg::STS_EMPTY) |-> m_occ_reg == '0)
        else $error("empty status with nonzero occupancy");

    // A shift pass follows a scan that chose an entry before the last one
    a_shift_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT && $past(state_reg) == ST_SCAN) |->
            dat_idx_reg == pos_reg + ADDR_W'(1))
        else $error("shift pass started at wrong entry");

endmodule
